FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertions with active-low reset disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define RMV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true out of reset
`define RMV_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: hdl/rmv_pkg.sv
// ----------------------------------------------------------------------------
// rmv_pkg
// widths, transfer payload types, controller states and serial unit
// request and response structs for the running mean and variance block
// ----------------------------------------------------------------------------
package rmv_pkg;

    localparam int TOTAL_W  = 32;
    localparam int SAMPLE_W = 24;
    localparam int COUNT_W  = 32;
    localparam int SUM_W    = 64;

    localparam int MUL_A_W   = 48;
    localparam int MUL_B_W   = 32;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 32;
    localparam int STEP_W  = $clog2(DIV_N_W) + 1;

    localparam logic [STEP_W-1:0] QUOT_STEPS = STEP_W'(SAMPLE_W);
    localparam logic [STEP_W-1:0] VAR_STEPS  = STEP_W'(SUM_W);

    typedef struct packed {
        logic [TOTAL_W-1:0]  event_total;
        logic [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_out;
        logic [COUNT_W-1:0]  count;
        logic [SAMPLE_W-1:0] mean;
        logic [SUM_W-1:0]    variance;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INC,
        ST_TEST,
        ST_SQ_WAIT,
        ST_SCALE,
        ST_SCALE_WAIT,
        ST_QUOT_WAIT,
        ST_PROD,
        ST_PROD_WAIT,
        ST_VAR,
        ST_VAR_WAIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PROD_W-1:0] product;
    } t_mul_rsp;

    typedef struct packed {
        logic               start;
        logic [STEP_W-1:0]  steps;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } t_div_rsp;

endpackage

FILE: hdl/running_mean_variance.sv
// ----------------------------------------------------------------------------
// running_mean_variance
// running mean and population variance of an energy sample, in fixed point
// ----------------------------------------------------------------------------
// Takes one input transfer at a time. A transfer whose event total has not
// grown past the last one seen is taken and gives no result. Otherwise one
// update per new event is applied with the same sample and a single result
// follows. Each update that still moves the mean runs a 24-bit quotient, then
// a 32-step product; the first update that leaves the mean where it is folds
// itself and all the rest into one square and one scale. The 64-bit variance
// division, the output load and the return to idle follow, and a finished
// result waits for the output register to free. The time is set by the
// 32-step serial multiplier and by the serial divider, which makes one
// quotient bit a cycle. The next input transfer is taken while a result
// still waits at the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module running_mean_variance (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  rmv_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output rmv_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);

    rmv_pkg::t_state r_state;
    rmv_pkg::t_state n_state;

    logic [rmv_pkg::TOTAL_W-1:0]  r_last;
    logic [rmv_pkg::COUNT_W-1:0]  r_cnt;
    logic [rmv_pkg::SAMPLE_W-1:0] r_mean;
    logic [rmv_pkg::SUM_W-1:0]    r_ssum;

    logic [rmv_pkg::SAMPLE_W-1:0]   r_x;
    logic [rmv_pkg::TOTAL_W-1:0]    r_left;
    logic                           r_neg;
    logic [rmv_pkg::SAMPLE_W-1:0]   r_ad;
    logic [rmv_pkg::SAMPLE_W-1:0]   r_dif;
    logic [2*rmv_pkg::SAMPLE_W-1:0] r_sq;

    logic               r_out_valid;
    rmv_pkg::t_out_item r_out;

    rmv_pkg::t_mul_req w_mul_req;
    rmv_pkg::t_mul_rsp w_mul_rsp;
    rmv_pkg::t_div_req w_div_req;
    rmv_pkg::t_div_rsp w_div_rsp;

    logic                           w_in_xfer;
    logic                           w_grown;
    logic                           w_neg;
    logic [rmv_pkg::SAMPLE_W-1:0]   w_ad;
    logic                           w_settle;
    logic [rmv_pkg::COUNT_W:0]      w_cnt_bulk;
    logic [rmv_pkg::COUNT_W-1:0]    w_cnt_sat;
    logic [rmv_pkg::SAMPLE_W-1:0]   w_q;
    logic [rmv_pkg::PROD_W:0]       w_acc_sum;
    logic [rmv_pkg::SUM_W-1:0]      w_acc_sat;
    logic                           w_out_free;

    rmv_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    rmv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_comb begin
        w_in_xfer  = i_in_valid && !o_in_stall;
        w_grown    = i_in_data.event_total > r_last;
        w_neg      = r_x < r_mean;
        w_ad       = w_neg ? (r_mean - r_x) : (r_x - r_mean);
        w_settle   = {{(rmv_pkg::COUNT_W-rmv_pkg::SAMPLE_W){1'b0}}, r_ad} < r_cnt;
        w_cnt_bulk = {1'b0, r_cnt} + {1'b0, r_left} - (rmv_pkg::COUNT_W+1)'(1);
        w_cnt_sat  = w_cnt_bulk[rmv_pkg::COUNT_W] ? '1 : w_cnt_bulk[rmv_pkg::COUNT_W-1:0];
        w_q        = w_div_rsp.quotient[rmv_pkg::SAMPLE_W-1:0];
        w_acc_sum  = {{(rmv_pkg::PROD_W-rmv_pkg::SUM_W+1){1'b0}}, r_ssum}
                   + {1'b0, w_mul_rsp.product};
        w_acc_sat  = (|w_acc_sum[rmv_pkg::PROD_W:rmv_pkg::SUM_W]) ? '1
                   : w_acc_sum[rmv_pkg::SUM_W-1:0];
        w_out_free = !r_out_valid || !i_out_stall;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rmv_pkg::ST_IDLE: begin
                if (w_in_xfer && w_grown) n_state = rmv_pkg::ST_INC;
            end
            rmv_pkg::ST_INC: n_state = rmv_pkg::ST_TEST;
            rmv_pkg::ST_TEST: begin
                n_state = w_settle ? rmv_pkg::ST_SQ_WAIT : rmv_pkg::ST_QUOT_WAIT;
            end
            rmv_pkg::ST_SQ_WAIT: begin
                if (w_mul_rsp.done) n_state = rmv_pkg::ST_SCALE;
            end
            rmv_pkg::ST_SCALE: n_state = rmv_pkg::ST_SCALE_WAIT;
            rmv_pkg::ST_SCALE_WAIT: begin
                if (w_mul_rsp.done) n_state = rmv_pkg::ST_VAR;
            end
            rmv_pkg::ST_QUOT_WAIT: begin
                if (w_div_rsp.done) n_state = rmv_pkg::ST_PROD;
            end
            rmv_pkg::ST_PROD: n_state = rmv_pkg::ST_PROD_WAIT;
            rmv_pkg::ST_PROD_WAIT: begin
                if (w_mul_rsp.done) begin
                    n_state = (r_left == rmv_pkg::TOTAL_W'(1)) ? rmv_pkg::ST_VAR
                                                               : rmv_pkg::ST_INC;
                end
            end
            rmv_pkg::ST_VAR: n_state = rmv_pkg::ST_VAR_WAIT;
            rmv_pkg::ST_VAR_WAIT: begin
                if (w_div_rsp.done) n_state = rmv_pkg::ST_EMIT;
            end
            rmv_pkg::ST_EMIT: begin
                if (w_out_free) n_state = rmv_pkg::ST_IDLE;
            end
            default: n_state = rmv_pkg::ST_IDLE;
        endcase
    end

    // unit requests and input stall
    always_comb begin
        w_mul_req.start    = 1'b0;
        w_mul_req.a        = {{(rmv_pkg::MUL_A_W-rmv_pkg::SAMPLE_W){1'b0}}, r_ad};
        w_mul_req.b        = {{(rmv_pkg::MUL_B_W-rmv_pkg::SAMPLE_W){1'b0}}, r_ad};
        w_div_req.start    = 1'b0;
        w_div_req.steps    = rmv_pkg::QUOT_STEPS;
        w_div_req.dividend = {r_ad, {(rmv_pkg::DIV_N_W-rmv_pkg::SAMPLE_W){1'b0}}};
        w_div_req.divisor  = r_cnt;
        o_in_stall         = r_state != rmv_pkg::ST_IDLE;
        unique case (r_state)
            rmv_pkg::ST_TEST: begin
                if (w_settle) begin
                    w_mul_req.start = 1'b1;
                end else begin
                    w_div_req.start = 1'b1;
                end
            end
            rmv_pkg::ST_SCALE: begin
                w_mul_req.start = 1'b1;
                w_mul_req.a     = r_sq;
                w_mul_req.b     = r_left;
            end
            rmv_pkg::ST_PROD: begin
                w_mul_req.start = 1'b1;
                w_mul_req.b     = {{(rmv_pkg::MUL_B_W-rmv_pkg::SAMPLE_W){1'b0}}, r_dif};
            end
            rmv_pkg::ST_VAR: begin
                w_div_req.start    = 1'b1;
                w_div_req.steps    = rmv_pkg::VAR_STEPS;
                w_div_req.dividend = r_ssum;
            end
            default: begin
                w_mul_req.start = 1'b0;
            end
        endcase
    end

    // control and accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmv_pkg::ST_IDLE;
            r_last      <= '0;
            r_cnt       <= '0;
            r_mean      <= '0;
            r_ssum      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == rmv_pkg::ST_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                rmv_pkg::ST_IDLE: begin
                    if (w_in_xfer && w_grown) r_last <= i_in_data.event_total;
                end
                rmv_pkg::ST_INC: begin
                    if (r_cnt != '1) r_cnt <= r_cnt + rmv_pkg::COUNT_W'(1);
                end
                rmv_pkg::ST_TEST: begin
                    // mean has settled: fold all remaining updates
                    if (w_settle) r_cnt <= w_cnt_sat;
                end
                rmv_pkg::ST_SCALE_WAIT: begin
                    if (w_mul_rsp.done) r_ssum <= w_acc_sat;
                end
                rmv_pkg::ST_QUOT_WAIT: begin
                    if (w_div_rsp.done) r_mean <= r_neg ? (r_mean - w_q) : (r_mean + w_q);
                end
                rmv_pkg::ST_PROD_WAIT: begin
                    if (w_mul_rsp.done) r_ssum <= w_acc_sat;
                end
                default: begin
                    r_last <= r_last;
                end
            endcase
        end
    end

    // working registers and result payload
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            rmv_pkg::ST_IDLE: begin
                if (w_in_xfer && w_grown) begin
                    r_x    <= i_in_data.sample;
                    r_left <= i_in_data.event_total - r_last;
                end
            end
            rmv_pkg::ST_INC: begin
                r_neg <= w_neg;
                r_ad  <= w_ad;
            end
            rmv_pkg::ST_SQ_WAIT: begin
                if (w_mul_rsp.done) r_sq <= w_mul_rsp.product[2*rmv_pkg::SAMPLE_W-1:0];
            end
            rmv_pkg::ST_QUOT_WAIT: begin
                if (w_div_rsp.done) r_dif <= r_ad - w_q;
            end
            rmv_pkg::ST_PROD_WAIT: begin
                if (w_mul_rsp.done && r_left != rmv_pkg::TOTAL_W'(1)) begin
                    r_left <= r_left - rmv_pkg::TOTAL_W'(1);
                end
            end
            rmv_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    r_out.sample_out <= r_x;
                    r_out.count      <= r_cnt;
                    r_out.mean       <= r_mean;
                    r_out.variance   <= w_div_rsp.quotient;
                end
            end
            default: begin
                r_x <= r_x;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // serial units are used one at a time
    `RMV_NEVER(a_units_excl, i_clk, i_rst_n, w_mul_rsp.busy && w_div_rsp.busy, "mul and div both busy")
    // at least one update outstanding while an item is in work
    `RMV_ASSERT(a_left_nz, i_clk, i_rst_n, (r_state != rmv_pkg::ST_IDLE) |-> (r_left != '0), "no update left in work")
    // the mean step lands where the remaining distance says
    `RMV_ASSERT(a_step_dist, i_clk, i_rst_n, (r_state == rmv_pkg::ST_PROD) |-> (w_ad == r_dif), "mean step off target")

endmodule

FILE: hdl/rmv_mul.sv
// ----------------------------------------------------------------------------
// rmv_mul
// bit-serial shift-and-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module rmv_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rmv_pkg::t_mul_req i_req,
    output rmv_pkg::t_mul_rsp o_rsp
);

    localparam logic [rmv_pkg::MUL_CNT_W-1:0] LAST_STEP =
        rmv_pkg::MUL_CNT_W'(rmv_pkg::MUL_B_W - 1);

    logic [rmv_pkg::MUL_A_W-1:0]   r_a;
    logic [rmv_pkg::MUL_A_W-1:0]   r_hi;
    logic [rmv_pkg::MUL_A_W-1:0]   n_hi;
    logic [rmv_pkg::MUL_B_W-1:0]   r_lo;
    logic [rmv_pkg::MUL_B_W-1:0]   n_lo;
    logic [rmv_pkg::MUL_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [rmv_pkg::MUL_A_W:0]     w_sum;

    always_comb begin
        w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);
        n_hi  = w_sum[rmv_pkg::MUL_A_W:1];
        n_lo  = {w_sum[0], r_lo[rmv_pkg::MUL_B_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + rmv_pkg::MUL_CNT_W'(1);
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a  <= i_req.a;
            r_hi <= '0;
            r_lo <= i_req.b;
        end else if (r_busy) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_rsp.busy    = r_busy;
    assign o_rsp.done    = r_done;
    assign o_rsp.product = {r_hi, r_lo};

endmodule

FILE: hdl/rmv_div.sv
// ----------------------------------------------------------------------------
// rmv_div
// bit-serial restoring divider, one quotient bit per cycle, run length
// set per request
// ----------------------------------------------------------------------------
module rmv_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rmv_pkg::t_div_req i_req,
    output rmv_pkg::t_div_rsp o_rsp
);

    logic [rmv_pkg::DIV_N_W-1:0] r_dvd;
    logic [rmv_pkg::DIV_N_W-1:0] n_dvd;
    logic [rmv_pkg::DIV_D_W-1:0] r_rem;
    logic [rmv_pkg::DIV_D_W-1:0] n_rem;
    logic [rmv_pkg::DIV_D_W-1:0] r_dsr;
    logic [rmv_pkg::STEP_W-1:0]  r_steps;
    logic [rmv_pkg::STEP_W-1:0]  r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [rmv_pkg::DIV_D_W:0]   w_rem_sh;
    logic [rmv_pkg::DIV_D_W:0]   w_diff;
    logic                        w_ge;

    always_comb begin
        w_rem_sh = {r_rem, r_dvd[rmv_pkg::DIV_N_W-1]};
        w_ge     = w_rem_sh >= {1'b0, r_dsr};
        w_diff   = w_rem_sh - {1'b0, r_dsr};
        n_rem    = w_ge ? w_diff[rmv_pkg::DIV_D_W-1:0] : w_rem_sh[rmv_pkg::DIV_D_W-1:0];
        n_dvd    = {r_dvd[rmv_pkg::DIV_N_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + rmv_pkg::STEP_W'(1);
                if (r_cnt + rmv_pkg::STEP_W'(1) == r_steps) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd   <= i_req.dividend;
            r_dsr   <= i_req.divisor;
            r_steps <= i_req.steps;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_dvd;

endmodule
